// ===== design/i2p_pkg.sv =====
// i2p_pkg: shared types, constants and character helpers for the
// infix-to-postfix converter. No dependencies.

package i2p_pkg;

  localparam int CHAR_W         = 8;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_OPEN  = 8'h28;  // '('
  localparam logic [CHAR_W-1:0] ASCII_CLOSE = 8'h29;  // ')'
  localparam logic [CHAR_W-1:0] ASCII_STAR  = 8'h2A;  // '*'
  localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] ASCII_SLASH = 8'h2F;  // '/'
  localparam logic [CHAR_W-1:0] ASCII_CARET = 8'h5E;  // '^'

  // closing-record status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  // kind of the character being worked on
  localparam logic [1:0] K_OP    = 2'd0;
  localparam logic [1:0] K_OPEN  = 2'd1;
  localparam logic [1:0] K_CLOSE = 2'd2;
  localparam logic [1:0] K_FIN   = 2'd3;

  localparam logic [2:0] PREC_NONE  = 3'd0;
  localparam logic [2:0] PREC_OPEN  = 3'd1;
  localparam logic [2:0] PREC_ADD   = 3'd2;
  localparam logic [2:0] PREC_MUL   = 3'd3;
  localparam logic [2:0] PREC_POW   = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              finish;
  } i2p_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              expr_done;
    logic [1:0]        status;
  } i2p_out_t;

  // shift control for the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } i2p_stk_t;

  function automatic logic [2:0] prec(input logic [CHAR_W-1:0] ch);
    logic [2:0] p;
    unique case (ch) inside
      ASCII_CARET:              p = PREC_POW;
      ASCII_STAR, ASCII_SLASH:  p = PREC_MUL;
      ASCII_PLUS, ASCII_MINUS:  p = PREC_ADD;
      ASCII_OPEN:               p = PREC_OPEN;
      default:                  p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  // whether another entry comes off the stack for this kind of character
  function automatic logic pop_more(input logic [1:0] kind, input logic [2:0] p,
                                    input logic [CHAR_W-1:0] top, input logic nonempty);
    logic m;
    unique case (kind)
      K_FIN:   m = nonempty;
      K_CLOSE: m = nonempty && (top != ASCII_OPEN);
      K_OP:    m = nonempty && (prec(top) >= p);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/i2p_cell.sv =====
// i2p_cell: one entry of the operator stack. Shifts toward the bottom on a
// push and toward the top on a pop. Depends on i2p_pkg.

module i2p_cell (
  input  logic                          clk,
  input  i2p_pkg::i2p_stk_t             ctrl,
  input  logic [i2p_pkg::CHAR_W-1:0]    from_above,
  input  logic [i2p_pkg::CHAR_W-1:0]    from_below,
  output logic [i2p_pkg::CHAR_W-1:0]    q
);
  import i2p_pkg::*;

  logic [CHAR_W-1:0] entry;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= from_above;
    end else if (ctrl.pop) begin
      entry <= from_below;
    end
  end

  assign q = entry;

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// infix_to_postfix_converter: shunting-yard converter, control FSM plus a
// row of i2p_cell stack entries. Depends on i2p_pkg and i2p_cell.
//
//   channel | direction | handshake               | beat type
//   char    | in        | char_valid / char_ready | i2p_in_t
//   text    | out       | text_valid / text_ready | i2p_out_t
//
// One character at a time. Letters, digits, signs and '.' are echoed;
// a space is dropped. An operator is accepted, then gets the leading space
// if owed, each popped entry (char, space) and the push/drop; finish takes
// the same steps but with the closing record in place of the push/drop.
// Cell 0 is the top of the stack.
// Reset (rst, synchronous) clears the count and flags; stack cells keep data.
// A stalled text beat holds the FSM; the next beat waits in the FSM, not lost.

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  i2p_pkg::i2p_in_t  char_data,
  output logic              text_valid,
  input  logic              text_ready,
  output i2p_pkg::i2p_out_t text_data
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAR  = 3'd1;
  localparam logic [2:0] S_SPACE = 3'd2;
  localparam logic [2:0] S_POPC  = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_CLOSE = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              at_start, at_start_next;
  logic              need_space, need_space_next;
  logic              after_open, after_open_next;
  logic [1:0]        error_code, error_code_next;
  logic [CHAR_W-1:0] cur_char, cur_char_next;
  logic [1:0]        cur_kind, cur_kind_next;
  logic [2:0]        cur_prec, cur_prec_next;

  logic              emit_req, can_emit;
  i2p_out_t          emit_beat;
  i2p_stk_t          stk;

  logic [CHAR_W-1:0] cell_q [STACK_DEPTH];
  logic [CHAR_W-1:0] top_q;
  logic              nonempty, more;
  logic              accept;
  logic [CHAR_W-1:0] c_in;
  logic [1:0]        kind_in;

  // ---- stack: row of cells ----
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = cur_char;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_q[i+1];
    end
    i2p_cell u_cell (
      .clk        (clk),
      .ctrl       (stk),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  assign top_q    = cell_q[0];
  assign nonempty = (count != '0);
  assign more     = pop_more(cur_kind, cur_prec, top_q, nonempty);
  assign can_emit = !text_valid || text_ready;

  assign char_ready = (state == S_IDLE);
  assign accept     = char_valid && char_ready;
  assign c_in       = char_data.in_char;

  always_comb begin
    if (char_data.finish) begin
      kind_in = K_FIN;
    end else if (c_in == ASCII_CLOSE) begin
      kind_in = K_CLOSE;
    end else if (c_in == ASCII_OPEN) begin
      kind_in = K_OPEN;
    end else begin
      kind_in = K_OP;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    at_start_next   = at_start;
    need_space_next = need_space;
    after_open_next = after_open;
    error_code_next = error_code;
    cur_char_next   = cur_char;
    cur_kind_next   = cur_kind;
    cur_prec_next   = cur_prec;
    emit_req        = 1'b0;
    emit_beat       = '0;
    stk             = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_char_next = c_in;
          cur_kind_next = kind_in;
          cur_prec_next = prec(c_in);
          if (char_data.finish) begin
            state_next = need_space ? S_SPACE : (nonempty ? S_POPC : S_CLOSE);
          end else if (c_in == ASCII_SPACE) begin
            state_next = S_IDLE;
          end else if (is_alnum(c_in)) begin
            need_space_next = 1'b1;
            after_open_next = 1'b0;
            at_start_next   = 1'b0;
            state_next      = S_CHAR;
          end else if ((c_in == ASCII_MINUS && (at_start || after_open)) ||
                       c_in == ASCII_DOT) begin
            state_next = S_CHAR;
          end else begin
            need_space_next = 1'b0;
            at_start_next   = 1'b0;
            if (need_space) begin
              state_next = S_SPACE;
            end else if (pop_more(kind_in, prec(c_in), top_q, nonempty)) begin
              state_next = S_POPC;
            end else begin
              state_next = S_ACT;
            end
          end
        end
      end
      S_CHAR: begin
        emit_req           = 1'b1;
        emit_beat.out_char = cur_char;
        emit_beat.run_last = 1'b1;
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      S_SPACE: begin
        // separator: leading space or the one after a popped entry
        emit_req           = 1'b1;
        emit_beat.out_char = ASCII_SPACE;
        emit_beat.run_last = (cur_kind != K_FIN) && !more;
        if (can_emit) begin
          if (more) begin
            state_next = S_POPC;
          end else begin
            state_next = (cur_kind == K_FIN) ? S_CLOSE : S_ACT;
          end
        end
      end
      S_POPC: begin
        emit_req           = 1'b1;
        emit_beat.out_char = top_q;
        if (can_emit) begin
          stk.pop    = 1'b1;
          count_next = count - CW'(1);
          state_next = S_SPACE;
        end
      end
      S_ACT: begin
        state_next = S_IDLE;
        case (cur_kind) inside
          K_OP, K_OPEN: begin
            if (count == FULL) begin
              if (error_code == ST_OK) error_code_next = ST_OVERFLOW;
            end else begin
              stk.push   = 1'b1;
              count_next = count + CW'(1);
            end
            if (cur_kind == K_OPEN) after_open_next = 1'b1;
          end
          K_CLOSE: begin
            if (nonempty) begin
              stk.pop    = 1'b1;  // drop the matching '('
              count_next = count - CW'(1);
            end else if (error_code == ST_OK) begin
              error_code_next = ST_UNMATCHED;
            end
          end
          default: ;
        endcase
      end
      S_CLOSE: begin
        emit_req            = 1'b1;
        emit_beat.out_char  = ASCII_NUL;
        emit_beat.run_last  = 1'b1;
        emit_beat.expr_done = 1'b1;
        emit_beat.status    = error_code;
        if (can_emit) begin
          count_next      = '0;
          at_start_next   = 1'b1;
          need_space_next = 1'b1;
          after_open_next = 1'b0;
          error_code_next = ST_OK;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      at_start   <= 1'b1;
      need_space <= 1'b1;
      after_open <= 1'b0;
      error_code <= ST_OK;
      text_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      at_start   <= at_start_next;
      need_space <= need_space_next;
      after_open <= after_open_next;
      error_code <= error_code_next;
      if (emit_req && can_emit) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_char <= cur_char_next;
    cur_kind <= cur_kind_next;
    cur_prec <= cur_prec_next;
    if (emit_req && can_emit) begin
      text_data <= emit_beat;
    end
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POPC |-> count != '0)
    else $error("pop from empty stack");

  a_status_only_close: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_data.expr_done |-> text_data.status == ST_OK)
    else $error("status on a non-closing beat");

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    state == S_CLOSE && can_emit |=> count == '0 && at_start && need_space &&
      !after_open && error_code == ST_OK)
    else $error("state not cleared after closing record");

  a_ready_idle_out: assert property (@(posedge clk) disable iff (rst)
    char_ready && text_valid |-> text_data.run_last)
    else $error("new beat accepted while previous item still emitting");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for infix_to_postfix_converter. Keeps its own
// operator-stack model, scores every text beat in order. Needs i2p_pkg.

module tb;
  import i2p_pkg::*;

  localparam int DEPTH     = STACK_DEPTH_DEF;
  localparam int ITEMS     = 430;
  localparam int LONG_HOLD = 300;
  localparam int WDOG_MAX  = 4000;
  localparam int END_WAIT  = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     char_valid = 1'b0;
  logic     char_ready;
  i2p_in_t  char_data = '0;
  logic     text_valid;
  logic     text_ready = 1'b0;
  i2p_out_t text_data;

  infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_data  (text_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [7:0] op_pile [DEPTH];
  int         pile_n;
  logic       fresh;        // nothing but signs/dots seen yet
  logic       want_gap;     // operand just ended, space owed
  logic       just_opened;
  logic [1:0] sticky_st;

  i2p_out_t postfix_q[$];
  int       errors;
  int       sent_items;
  int       tx_idle_pct;
  int       rx_idle_pct;
  int       hold_reqs;
  int       holds_seen;
  int       rx_gap;
  int       quiet;

  initial begin
    errors = 0;
    sent_items = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs = 0;
    holds_seen = 0;
    rx_gap = 0;
    quiet = 0;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int op_rank(input logic [7:0] c);
    case (c) inside
      ASCII_CARET:              return PREC_POW;
      ASCII_STAR, ASCII_SLASH:  return PREC_MUL;
      ASCII_PLUS, ASCII_MINUS:  return PREC_ADD;
      ASCII_OPEN:               return PREC_OPEN;
      default:                  return PREC_NONE;
    endcase
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_state();
    pile_n = 0;
    fresh = 1'b1;
    want_gap = 1'b1;
    just_opened = 1'b0;
    sticky_st = ST_OK;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    postfix_q.push_back('{out_char: c, run_last: 1'b0, expr_done: 1'b0, status: ST_OK});
  endfunction

  function automatic void pop_to_text();
    pile_n--;
    put_char(op_pile[pile_n]);
    put_char(ASCII_SPACE);
  endfunction

  function automatic void flag(input logic [1:0] st);
    if (sticky_st == ST_OK) sticky_st = st;
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (pile_n >= DEPTH) begin
      flag(ST_OVERFLOW);
    end else begin
      op_pile[pile_n] = c;
      pile_n++;
    end
  endfunction

  // expected postfix beats for one accepted character
  function automatic void convert_char(input i2p_in_t it);
    logic [7:0] c;
    int         n0;
    c  = it.in_char;
    n0 = postfix_q.size();
    if (it.finish) begin
      if (want_gap) put_char(ASCII_SPACE);
      while (pile_n > 0) pop_to_text();
      postfix_q.push_back('{out_char: ASCII_NUL, run_last: 1'b0, expr_done: 1'b1,
                            status: sticky_st});
      clear_state();
    end else if (c == ASCII_SPACE) begin
      // dropped
    end else if (is_word_char(c)) begin
      want_gap = 1'b1;
      just_opened = 1'b0;
      put_char(c);
      fresh = 1'b0;
    end else if ((fresh || just_opened) && c == ASCII_MINUS) begin
      put_char(c);
    end else if (c == ASCII_DOT) begin
      put_char(c);
    end else begin
      if (want_gap) begin
        put_char(ASCII_SPACE);
        want_gap = 1'b0;
      end
      if (c == ASCII_CLOSE) begin
        while (pile_n > 0 && op_pile[pile_n-1] != ASCII_OPEN) pop_to_text();
        if (pile_n > 0) pile_n--;
        else flag(ST_UNMATCHED);
      end else if (c == ASCII_OPEN) begin
        push_op(c);
        just_opened = 1'b1;
      end else begin
        while (pile_n > 0 && op_rank(op_pile[pile_n-1]) >= op_rank(c)) pop_to_text();
        push_op(c);
      end
      fresh = 1'b0;
    end
    if (postfix_q.size() > n0) postfix_q[$].run_last = 1'b1;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != holds_seen) begin
      holds_seen = hold_reqs;
      rx_gap = LONG_HOLD;
    end
    if (rx_gap > 0) begin
      text_ready <= 1'b0;
      rx_gap = rx_gap - 1;
    end else begin
      text_ready <= 1'b1;
      rx_gap = pick_gap(rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_text
    i2p_out_t want;
    if (!rst && text_valid && text_ready) begin
      if (postfix_q.size() == 0) begin
        $display("%0t: text beat with nothing pending: got %h", $time, text_data);
        errors++;
      end else begin
        want = postfix_q.pop_front();
        if (text_data.out_char !== want.out_char) begin
          $display("%0t: out_char exp %h got %h", $time, want.out_char, text_data.out_char);
          errors++;
        end
        if (text_data.run_last !== want.run_last) begin
          $display("%0t: run_last exp %b got %b", $time, want.run_last, text_data.run_last);
          errors++;
        end
        if (text_data.expr_done !== want.expr_done) begin
          $display("%0t: expr_done exp %b got %b", $time, want.expr_done,
                   text_data.expr_done);
          errors++;
        end
        if (text_data.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, text_data.status);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((char_valid && char_ready) || (text_valid && text_ready)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= WDOG_MAX) begin
      $display("%0t: no progress for %0d cycles, %0d beats pending", $time, quiet,
               postfix_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input logic [7:0] c, input logic fin);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{in_char: c, finish: fin};
    do @(posedge clk); while (!char_ready);
    convert_char(char_data);
    if (fin || c != ASCII_SPACE) sent_items++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send(c, 1'b0);
  endtask

  task automatic send_finish();
    send(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain_text();
    char_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return ASCII_CARET;
      1:       return ASCII_STAR;
      2:       return ASCII_SLASH;
      3:       return ASCII_PLUS;
      default: return ASCII_MINUS;
    endcase
  endfunction

  task automatic send_operand();
    if ($urandom_range(0, 5) == 0) send_char(ASCII_MINUS);
    repeat ($urandom_range(1, 3)) send_char(rand_word_char());
    if ($urandom_range(0, 4) == 0) begin
      send_char(ASCII_DOT);
      send_char(8'("0" + $urandom_range(0, 9)));
    end
  endtask

  // mostly balanced expression; now and then a bracket is dropped or extra
  task automatic send_expression();
    int terms;
    int depth;
    terms = $urandom_range(1, 8);
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(0, 5) == 0) send_char(ASCII_SPACE);
      while ($urandom_range(0, 3) == 0 && depth < 20) begin
        send_char(ASCII_OPEN);
        depth++;
      end
      send_operand();
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_char(ASCII_CLOSE);
        depth--;
      end
      if (t < terms - 1) send_char(rand_op());
    end
    if ($urandom_range(0, 7) != 0)
      repeat (depth) send_char(ASCII_CLOSE);
    if ($urandom_range(0, 9) == 0) send_char(ASCII_CLOSE);
    send_finish();
  endtask

  // nests near or past the stack depth, flush is long
  task automatic send_deep_nest();
    int n;
    n = $urandom_range(DEPTH - 4, DEPTH + 4);
    repeat (n) send_char(ASCII_OPEN);
    send_operand();
    if ($urandom_range(0, 1) == 0) repeat (n) send_char(ASCII_CLOSE);
    send_finish();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)));
    send_finish();
  endtask

  task automatic test_chars();
    send_str("-a+(-9.)*Z^ /z");
    send_char(8'h00);
    send_char(8'hFF);
    send_finish();
  endtask

  // unmatched close first, then overflow; the first error must stick
  task automatic test_sticky_errors();
    send_char(ASCII_CLOSE);
    repeat (DEPTH + 1) send_char(ASCII_OPEN);
    send_finish();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    send_str("(a+b)*(c-d)/e^f^g+h*i-j");
    send_finish();
  endtask

  task automatic test_drain_pause();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send_str("x1.5*y");
    drain_text();
    send_str("-(p");
    send_finish();
    drain_text();
  endtask

  task automatic test_random();
    int kind;
    while (sent_items < ITEMS) begin
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 15;
        default: tx_idle_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_idle_pct = 0;
        1:       rx_idle_pct = 15;
        default: rx_idle_pct = 50;
      endcase
      kind = $urandom_range(0, 9);
      if (kind < 7) send_expression();
      else if (kind == 7) send_deep_nest();
      else send_noise();
      if ($urandom_range(0, 9) == 0) drain_text();
    end
  endtask

  initial begin
    clear_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_chars();
    test_sticky_errors();
    test_backpressure();
    test_drain_pause();
    test_random();
    drain_text();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
